/* rtl/qzoc_pkg.sv */
// Package for the quaternion zero-offset corrector.
// Holds the command, status and register codes, the sequencer types and the width helpers.
// No dependencies.
package qzoc_pkg;

	localparam int FRAC_BITS_DEF = 14;

	// Command codes carried by func.
	localparam logic [1:0] FN_APPLY = 2'd0;
	localparam logic [1:0] FN_ZERO  = 2'd1;
	localparam logic [1:0] FN_RESET = 2'd2;

	// Result status codes.
	localparam logic [2:0] ST_CORR     = 3'd0;
	localparam logic [2:0] ST_PASS     = 3'd1;
	localparam logic [2:0] ST_INVALID  = 3'd2;
	localparam logic [2:0] ST_DRIFT    = 3'd3;
	localparam logic [2:0] ST_ZERO_SET = 3'd4;
	localparam logic [2:0] ST_ZERO_REJ = 3'd5;
	localparam logic [2:0] ST_RESET    = 3'd6;

	// Configuration register indexes.
	localparam logic [2:0] CFG_VALID_TOL  = 3'd0;
	localparam logic [2:0] CFG_DRIFT_THR  = 3'd1;
	localparam logic [2:0] CFG_DRIFT_LIM  = 3'd2;
	localparam logic [2:0] CFG_CHECK_INT  = 3'd3;
	localparam logic [2:0] CFG_RENORM_THR = 3'd4;

	localparam logic [14:0] VALID_TOL_RST  = 15'd1638;
	localparam logic [14:0] DRIFT_THR_RST  = 15'd1638;
	localparam logic [3:0]  DRIFT_LIM_RST  = 4'd5;
	localparam logic [15:0] CHECK_INT_RST  = 16'd1000;
	localparam logic [14:0] RENORM_THR_RST = 15'd82;

	// Subtraction pattern of the Hamilton product: bit k set means term k is subtracted
	// for result component i. Term k pairs offset[k] with input[i ^ k].
	localparam logic [3:0] NEG_MASK [4] = '{4'b1110, 4'b1000, 4'b0010, 4'b0100};

	typedef enum logic [3:0] {
		S_IDLE, S_SQ, S_SQRT, S_PROD, S_DIV, S_DIVW, S_FIN, S_MOD, S_OUT
	} state_t;

	typedef enum logic [1:0] {
		PH_QCHK, PH_PNORM, PH_ONORM
	} phase_t;

	typedef struct packed {
		logic issue;
		logic first;
		logic neg;
	} mac_ctrl_t;

	typedef struct packed {
		logic start;
		logic sqrt;
	} sd_ctrl_t;

	// Operand width of the multiplier: wide enough for an input component and for an
	// unsaturated product component.
	function automatic int op_w(input int f);
		return (35 - f > 17) ? 35 - f : 17;
	endfunction

	function automatic int acc_w(input int f);
		return 2 * op_w(f) + 2;
	endfunction

	function automatic int rt_w(input int f);
		return op_w(f) + 1;
	endfunction

	function automatic int num_w(input int f);
		return (f + 17 > 36) ? f + 17 : 36;
	endfunction

endpackage

/* rtl/qzoc_mac.sv */
// Shared multiply-accumulate unit of the corrector.
// One registered multiplier followed by a signed accumulator; uses qzoc_pkg.
module qzoc_mac import qzoc_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	localparam int OP_W = op_w(FRAC_BITS),
	localparam int ACC_W = acc_w(FRAC_BITS)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mac_ctrl_t               ctrl,
	input  logic signed [OP_W-1:0]  a,
	input  logic signed [OP_W-1:0]  b,
	output logic signed [ACC_W-1:0] acc
);

	logic                     vld_s1;
	logic                     first_s1;
	logic                     neg_s1;
	logic signed [2*OP_W-1:0] prod_s1;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  term;

	assign term = neg_s1 ? -ACC_W'(prod_s1) : ACC_W'(prod_s1);
	assign acc  = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= ctrl.issue;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1  <= a * b;
		first_s1 <= ctrl.first;
		neg_s1   <= ctrl.neg;
		if (vld_s1) begin
			acc_q <= (first_s1 ? '0 : acc_q) + term;
		end
	end

endmodule

/* rtl/qzoc_sqdiv.sv */
// Bit-serial shift-subtract unit: integer square root (two bits a step) or
// restoring division (one bit a step), sharing one compare and subtract. Uses qzoc_pkg.
module qzoc_sqdiv import qzoc_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	localparam int RT_W = rt_w(FRAC_BITS),
	localparam int SQ_W = acc_w(FRAC_BITS),
	localparam int NUM_W = num_w(FRAC_BITS)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  sd_ctrl_t         ctrl,
	input  logic [SQ_W-1:0]  sq_in,
	input  logic [NUM_W-1:0] num_in,
	input  logic [RT_W-1:0]  den_in,
	output logic             done,
	output logic [RT_W-1:0]  root,
	output logic [NUM_W-1:0] quo,
	output logic [RT_W-1:0]  rem
);

	localparam int SRC_W = (SQ_W > NUM_W) ? SQ_W : NUM_W;
	localparam int RW    = RT_W + 2;
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [SRC_W-1:0] src_q;
	logic [RW-1:0]    rem_q;
	logic [NUM_W-1:0] res_q;
	logic [RT_W-1:0]  den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             mode_q;
	logic             done_q;
	logic [RW-1:0]    cand;
	logic [RW-1:0]    sub;
	logic             ge;

	always_comb begin
		if (mode_q) begin
			cand = {rem_q[RW-3:0], src_q[SRC_W-1 -: 2]};
			sub  = {res_q[RT_W-1:0], 2'b01};
		end else begin
			cand = {rem_q[RW-2:0], src_q[SRC_W-1]};
			sub  = {2'b00, den_q};
		end
		ge = (cand >= sub);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			mode_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start) begin
				busy_q <= 1'b1;
				mode_q <= ctrl.sqrt;
				cnt_q  <= ctrl.sqrt ? CNT_W'(RT_W) : CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			src_q <= ctrl.sqrt ? (SRC_W'(sq_in) << (SRC_W - SQ_W))
			                   : (SRC_W'(num_in) << (SRC_W - NUM_W));
			rem_q <= '0;
			res_q <= '0;
			den_q <= den_in;
		end else if (busy_q) begin
			rem_q <= ge ? (cand - sub) : cand;
			res_q <= {res_q[NUM_W-2:0], ge};
			src_q <= mode_q ? (src_q << 2) : (src_q << 1);
		end
	end

	assign done = done_q;
	assign root = res_q[RT_W-1:0];
	assign quo  = res_q;
	assign rem  = rem_q[RT_W-1:0];

endmodule

/* rtl/quaternion_zero_offset_corrector_top.sv */
// Top level of the quaternion zero-offset corrector: sequencer, state and registers.
// Uses qzoc_pkg, qzoc_mac and qzoc_sqdiv.
//
//   channel | signals                                   | direction
//   in      | in_valid, in_ready, func, q_w..q_z        | item in
//   out     | out_valid, out_ready, out_w..out_z, stats | result out
//   cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | register write
//
// One item is worked on at a time; in_ready is low from its transfer until its result
// has been taken. Reset, pass-through and unknown commands go straight to the output
// state; a corrected sample passes through the bit-serial square root and divider (two
// roots, up to five divisions); a periodic renormalisation passes through them again.
// A stalled result simply holds the block in its output state. Reset is asynchronous.
module quaternion_zero_offset_corrector_top import qzoc_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         func,
	input  logic signed [15:0] q_w,
	input  logic signed [15:0] q_x,
	input  logic signed [15:0] q_y,
	input  logic signed [15:0] q_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] out_w,
	output logic signed [15:0] out_x,
	output logic signed [15:0] out_y,
	output logic signed [15:0] out_z,
	output logic [2:0]         status,
	output logic               recalibrate,
	output logic               offset_active,
	output logic [31:0]        sample_count,
	output logic [31:0]        correction_count,
	output logic [14:0]        norm_deviation,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	localparam int OP_W  = op_w(FRAC_BITS);
	localparam int ACC_W = acc_w(FRAC_BITS);
	localparam int RT_W  = rt_w(FRAC_BITS);
	localparam int NUM_W = num_w(FRAC_BITS);
	localparam int CMP_W = (RT_W > FRAC_BITS + 2) ? RT_W : FRAC_BITS + 2;
	localparam logic [CMP_W-1:0] ONE_C  = CMP_W'(1) << FRAC_BITS;
	localparam logic [ACC_W:0]   HALF_C = (ACC_W + 1)'(1) << (FRAC_BITS - 1);
	localparam logic signed [15:0] ID_Q = (FRAC_BITS >= 15) ? 16'sh7fff : 16'(1 << FRAC_BITS);
	localparam logic [2:0] K_LAST = 3'd5;

	state_t state_q, state_d;
	phase_t phase_q;
	logic [2:0]  k_q;
	logic [1:0]  idx_q;
	logic [1:0]  func_q;

	logic [14:0] tol_q, thr_q, renorm_q;
	logic [3:0]  lim_q;
	logic [15:0] chk_int_q;

	logic signed [15:0]     q_q   [4];
	logic signed [OP_W-1:0] vec_q [4];
	logic signed [15:0]     off_q [4];
	logic signed [15:0]     nrm_q [4];
	logic signed [15:0]     res_q [4];
	logic [RT_W-1:0]        n_q;
	logic [2:0]             status_q;
	logic                   recal_q;
	logic                   valid_q;
	logic [31:0]            samp_q, corr_q;
	logic [14:0]            dev_q;
	logic [3:0]             run_q;

	mac_ctrl_t              mac_c;
	sd_ctrl_t               sd_c;
	logic signed [OP_W-1:0] mac_a, mac_b;
	logic signed [ACC_W-1:0] acc;
	logic                   sd_done;
	logic [RT_W-1:0]        sd_root, sd_rem;
	logic [NUM_W-1:0]       sd_quo, sd_num, numer;
	logic [RT_W-1:0]        sd_den;

	logic                   k_last;
	logic [ACC_W-1:0]       acc_mag;
	logic [ACC_W:0]         acc_rnd;
	logic signed [OP_W-1:0] rnd_mag, p_val;
	logic [CMP_W-1:0]       n_ext, dev_raw;
	logic [14:0]            dev_new;
	logic signed [OP_W-1:0] v_sel;
	logic [OP_W-1:0]        v_mag;
	logic signed [15:0]     q16;
	logic [3:0]             run_inc;
	logic                   drift, trip, renorm_go;
	logic [31:0]            samp_inc;

	assign k_last = (k_q == K_LAST);

	// Rounding of a product sum to Q(F), halves away from zero.
	always_comb begin
		acc_mag = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
		acc_rnd = ({1'b0, acc_mag} + HALF_C) >> FRAC_BITS;
		rnd_mag = OP_W'(acc_rnd);
		p_val   = acc[ACC_W-1] ? -rnd_mag : rnd_mag;
	end

	always_comb begin
		n_ext   = CMP_W'(sd_root);
		dev_raw = (n_ext > ONE_C) ? (n_ext - ONE_C) : (ONE_C - n_ext);
		dev_new = (dev_raw > CMP_W'(32767)) ? 15'h7fff : dev_raw[14:0];
	end

	// Normalisation of one component: |c|*ONE + n/2 divided by n, then signed and saturated.
	always_comb begin
		v_sel = vec_q[idx_q];
		v_mag = v_sel[OP_W-1] ? OP_W'(-v_sel) : OP_W'(v_sel);
		numer = (NUM_W'(v_mag) << FRAC_BITS) + NUM_W'(n_q >> 1);
		if (!v_sel[OP_W-1]) begin
			q16 = (sd_quo > NUM_W'(32767)) ? 16'sh7fff : signed'(sd_quo[15:0]);
		end else begin
			q16 = (sd_quo > NUM_W'(32768)) ? 16'sh8000 : -signed'(sd_quo[15:0]);
		end
	end

	always_comb begin
		run_inc   = (run_q == 4'd15) ? 4'd15 : run_q + 4'd1;
		drift     = (dev_q > thr_q);
		trip      = drift && (run_inc >= lim_q);
		samp_inc  = samp_q + 32'd1;
		renorm_go = (sd_rem == '0) && (dev_q > renorm_q);
	end

	always_comb begin
		if (state_q == S_PROD) begin
			mac_a = OP_W'(off_q[k_q[1:0]]);
			mac_b = OP_W'(q_q[idx_q ^ k_q[1:0]]);
		end else begin
			mac_a = vec_q[k_q[1:0]];
			mac_b = vec_q[k_q[1:0]];
		end
		sd_num = (state_q == S_FIN) ? NUM_W'(samp_inc) : numer;
		sd_den = (state_q == S_FIN) ? RT_W'(chk_int_q) : n_q;
	end

	qzoc_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
		.clk(clk), .arst_n(arst_n), .ctrl(mac_c), .a(mac_a), .b(mac_b), .acc(acc)
	);

	qzoc_sqdiv #(.FRAC_BITS(FRAC_BITS)) u_sqdiv (
		.clk(clk), .arst_n(arst_n), .ctrl(sd_c), .sq_in($unsigned(acc)),
		.num_in(sd_num), .den_in(sd_den), .done(sd_done), .root(sd_root),
		.quo(sd_quo), .rem(sd_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		sd_c        = '0;
		mac_c.issue = ((state_q == S_SQ) || (state_q == S_PROD)) && !k_q[2];
		mac_c.first = (k_q == 3'd0);
		mac_c.neg   = (state_q == S_PROD) && NEG_MASK[idx_q][k_q[1:0]];
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (func)
						FN_ZERO:  state_d = S_SQ;
						FN_APPLY: state_d = valid_q ? S_SQ : S_OUT;
						default:  state_d = S_OUT;
					endcase
				end
			end
			S_SQ: begin
				if (k_last) begin
					sd_c.start = 1'b1;
					sd_c.sqrt  = 1'b1;
					state_d    = S_SQRT;
				end
			end
			S_SQRT: begin
				if (sd_done) begin
					if (phase_q == PH_QCHK) begin
						if (dev_new > tol_q) begin
							state_d = S_OUT;
						end else begin
							state_d = (func_q == FN_ZERO) ? S_DIV : S_PROD;
						end
					end else begin
						state_d = S_DIV;
					end
				end
			end
			S_PROD: begin
				if (k_last && (idx_q == 2'd3)) begin
					state_d = S_SQ;
				end
			end
			S_DIV: begin
				if (n_q == '0) begin
					state_d = S_FIN;
				end else begin
					sd_c.start = 1'b1;
					state_d    = S_DIVW;
				end
			end
			S_DIVW: begin
				if (sd_done) begin
					state_d = (idx_q == 2'd3) ? S_FIN : S_DIV;
				end
			end
			S_FIN: begin
				state_d = S_OUT;
				if ((phase_q == PH_PNORM) && !trip && (chk_int_q != 16'd0)) begin
					sd_c.start = 1'b1;
					state_d    = S_MOD;
				end
			end
			S_MOD: begin
				if (sd_done) begin
					state_d = renorm_go ? S_SQ : S_OUT;
				end
			end
			S_OUT: begin
				if (out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Control and block state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_QCHK;
			k_q       <= '0;
			idx_q     <= '0;
			valid_q   <= 1'b0;
			off_q     <= '{ID_Q, 16'sd0, 16'sd0, 16'sd0};
			samp_q    <= '0;
			corr_q    <= '0;
			dev_q     <= '0;
			run_q     <= '0;
			tol_q     <= VALID_TOL_RST;
			thr_q     <= DRIFT_THR_RST;
			lim_q     <= DRIFT_LIM_RST;
			chk_int_q <= CHECK_INT_RST;
			renorm_q  <= RENORM_THR_RST;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_VALID_TOL:  tol_q     <= cfg_data[14:0];
					CFG_DRIFT_THR:  thr_q     <= cfg_data[14:0];
					CFG_DRIFT_LIM:  lim_q     <= cfg_data[3:0];
					CFG_CHECK_INT:  chk_int_q <= cfg_data;
					CFG_RENORM_THR: renorm_q  <= cfg_data[14:0];
					default: ;
				endcase
			end
			if ((state_q == S_SQ) || (state_q == S_PROD)) begin
				k_q <= k_last ? 3'd0 : k_q + 3'd1;
			end else begin
				k_q <= '0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						phase_q <= PH_QCHK;
						if (func == FN_RESET) begin
							off_q   <= '{ID_Q, 16'sd0, 16'sd0, 16'sd0};
							valid_q <= 1'b0;
							samp_q  <= '0;
							corr_q  <= '0;
							dev_q   <= '0;
						end
					end
				end
				S_SQRT: begin
					if (sd_done) begin
						idx_q <= '0;
						if (phase_q == PH_PNORM) begin
							dev_q <= dev_new;
						end
					end
				end
				S_PROD: begin
					if (k_last) begin
						idx_q <= idx_q + 2'd1;
						if (idx_q == 2'd3) begin
							phase_q <= PH_PNORM;
						end
					end
				end
				S_DIVW: begin
					if (sd_done) begin
						idx_q <= idx_q + 2'd1;
					end
				end
				S_FIN: begin
					case (phase_q)
						PH_QCHK: begin
							off_q   <= nrm_q;
							valid_q <= 1'b1;
							samp_q  <= 32'd1;
							corr_q  <= '0;
						end
						PH_PNORM: begin
							if (trip) begin
								off_q   <= '{ID_Q, 16'sd0, 16'sd0, 16'sd0};
								valid_q <= 1'b0;
								samp_q  <= '0;
								corr_q  <= '0;
								dev_q   <= '0;
								run_q   <= '0;
							end else begin
								run_q  <= drift ? run_inc : 4'd0;
								samp_q <= samp_inc;
							end
						end
						PH_ONORM: begin
							off_q  <= nrm_q;
							corr_q <= corr_q + 32'd1;
						end
						default: ;
					endcase
				end
				S_MOD: begin
					if (sd_done && renorm_go) begin
						phase_q <= PH_ONORM;
					end
				end
				default: ;
			endcase
		end
	end

	// Operands and result registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					func_q  <= func;
					q_q     <= '{q_w, q_x, q_y, q_z};
					recal_q <= 1'b0;
					// The conjugate has the same norm, so a new zero point is checked on it.
					if (func == FN_ZERO) begin
						vec_q <= '{OP_W'(q_w), -OP_W'(q_x), -OP_W'(q_y), -OP_W'(q_z)};
					end else begin
						vec_q <= '{OP_W'(q_w), OP_W'(q_x), OP_W'(q_y), OP_W'(q_z)};
					end
					case (func)
						FN_RESET: begin
							res_q    <= '{ID_Q, 16'sd0, 16'sd0, 16'sd0};
							status_q <= ST_RESET;
						end
						FN_ZERO: ;
						FN_APPLY: begin
							if (!valid_q) begin
								res_q    <= '{q_w, q_x, q_y, q_z};
								status_q <= ST_PASS;
							end
						end
						default: begin
							res_q    <= off_q;
							status_q <= ST_ZERO_REJ;
						end
					endcase
				end
			end
			S_SQRT: begin
				if (sd_done) begin
					n_q <= sd_root;
					if ((phase_q == PH_QCHK) && (dev_new > tol_q)) begin
						if (func_q == FN_ZERO) begin
							res_q    <= off_q;
							status_q <= ST_ZERO_REJ;
						end else begin
							res_q    <= '{ID_Q, 16'sd0, 16'sd0, 16'sd0};
							status_q <= ST_INVALID;
						end
					end
				end
			end
			S_PROD: begin
				if (k_last) begin
					vec_q[idx_q] <= p_val;
				end
			end
			S_DIV: begin
				if (n_q == '0) begin
					nrm_q <= '{ID_Q, 16'sd0, 16'sd0, 16'sd0};
				end
			end
			S_DIVW: begin
				if (sd_done) begin
					nrm_q[idx_q] <= q16;
				end
			end
			S_FIN: begin
				case (phase_q)
					PH_QCHK: begin
						res_q    <= nrm_q;
						status_q <= ST_ZERO_SET;
					end
					PH_PNORM: begin
						res_q    <= nrm_q;
						status_q <= trip ? ST_DRIFT : ST_CORR;
						recal_q  <= trip;
					end
					default: ;
				endcase
			end
			S_MOD: begin
				if (sd_done && renorm_go) begin
					vec_q <= '{OP_W'(off_q[0]), OP_W'(off_q[1]), OP_W'(off_q[2]),
					           OP_W'(off_q[3])};
				end
			end
			default: ;
		endcase
	end

	assign in_ready         = (state_q == S_IDLE);
	assign out_valid        = (state_q == S_OUT);
	assign cfg_ready        = 1'b1;
	assign out_w            = res_q[0];
	assign out_x            = res_q[1];
	assign out_y            = res_q[2];
	assign out_z            = res_q[3];
	assign status           = status_q;
	assign recalibrate      = recal_q;
	assign offset_active    = valid_q;
	assign sample_count     = samp_q;
	assign correction_count = corr_q;
	assign norm_deviation   = dev_q;

endmodule

/* rtl/qzoc_checker.sv */
// Port-level checks for the quaternion zero-offset corrector, bound to its top level.
// Uses qzoc_pkg for the status codes.
module qzoc_checker import qzoc_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [15:0] out_w,
	input logic [2:0]         status,
	input logic               recalibrate,
	input logic               offset_active,
	input logic [31:0]        sample_count
);

	// One item at a time: the block never takes a transfer while a result is pending.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input accepted while a result is pending");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_w) && $stable(status))
		else $error("stalled result changed");

	a_drift_reset: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_DRIFT) |-> recalibrate && !offset_active
			&& (sample_count == 32'd0))
		else $error("drift reset left offset state behind");

	a_zero_set: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_ZERO_SET) |-> offset_active && !recalibrate
			&& (sample_count == 32'd1))
		else $error("zero point accepted without arming the offset");

	a_pass: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_PASS) |-> !offset_active && !recalibrate)
		else $error("pass-through with an active offset");

endmodule

bind quaternion_zero_offset_corrector_top qzoc_checker u_qzoc_checker (.*);

/* tb/tb.sv */
// Self-checking testbench for quaternion_zero_offset_corrector_top.
// Depends on qzoc_pkg and the RTL only; a scoreboard class predicts every result.
`timescale 1ns / 100ps

typedef longint quat_t [4];

typedef struct {
	logic signed [15:0] w, x, y, z;
	logic [2:0]         st;
	logic               recal;
	logic               active;
	logic [31:0]        samples;
	logic [31:0]        renorms;
	logic [14:0]        dev;
} quat_result_t;

class corrected_quat_board;
	int unsigned valid_tol, drift_thr, drift_lim, check_int, renorm_thr;
	longint offset [4];
	bit offset_set;
	bit [31:0] samples_seen, renorm_count;
	longint last_dev;
	int unsigned drift_run;
	quat_result_t pending_results [$];
	int errors, reported;
	int status_seen [8];

	function new();
		valid_tol = 1638; drift_thr = 1638; drift_lim = 5; check_int = 1000; renorm_thr = 82;
		clear_offset();
		drift_run = 0;
	endfunction

	function void clear_offset();
		offset[0] = 16384; offset[1] = 0; offset[2] = 0; offset[3] = 0;
		offset_set = 0; samples_seen = 0; renorm_count = 0; last_dev = 0;
	endfunction

	function void write_reg(logic [2:0] idx, logic [15:0] data);
		case (idx)
			qzoc_pkg::CFG_VALID_TOL:  valid_tol = data[14:0];
			qzoc_pkg::CFG_DRIFT_THR:  drift_thr = data[14:0];
			qzoc_pkg::CFG_DRIFT_LIM:  drift_lim = data[3:0];
			qzoc_pkg::CFG_CHECK_INT:  check_int = data;
			qzoc_pkg::CFG_RENORM_THR: renorm_thr = data[14:0];
			default: ;
		endcase
	endfunction

	function longint mag(longint v);
		return v < 0 ? -v : v;
	endfunction

	function longint sat16(longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	function longint root_floor(longint v);
		longint res, b;
		res = 0;
		b = longint'(1) << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function longint norm_of(quat_t c);
		longint s;
		s = 0;
		for (int i = 0; i < 4; i++) s += mag(c[i]) * mag(c[i]);
		return root_floor(s);
	endfunction

	// Scales c to unit length; a zero vector becomes identity. Returns the norm.
	function longint unit_scale(quat_t c, output quat_t q);
		longint n, r;
		n = norm_of(c);
		if (n == 0) begin
			q[0] = 16384; q[1] = 0; q[2] = 0; q[3] = 0;
			return 0;
		end
		for (int i = 0; i < 4; i++) begin
			r = (mag(c[i]) * 16384 + n / 2) / n;
			q[i] = sat16(c[i] < 0 ? -r : r);
		end
		return n;
	endfunction

	function longint dev_of(longint n);
		longint d;
		d = n > 16384 ? n - 16384 : 16384 - n;
		return d > 32767 ? 32767 : d;
	endfunction

	function longint round_q(longint v);
		longint m;
		m = (mag(v) + 8192) >>> 14;
		return v < 0 ? -m : m;
	endfunction

	function void note_sample(logic [1:0] fn, logic signed [15:0] w, x, y, z);
		quat_t q, res, c, p, t;
		quat_result_t e;
		logic [2:0] st;
		bit recal;
		recal = 0;
		q[0] = w; q[1] = x; q[2] = y; q[3] = z;
		res = offset;
		if (fn == qzoc_pkg::FN_ZERO) begin
			if (dev_of(norm_of(q)) > valid_tol) begin
				st = qzoc_pkg::ST_ZERO_REJ;
			end else begin
				c[0] = q[0]; c[1] = -q[1]; c[2] = -q[2]; c[3] = -q[3];
				void'(unit_scale(c, offset));
				offset_set = 1; samples_seen = 1; renorm_count = 0;
				res = offset;
				st = qzoc_pkg::ST_ZERO_SET;
			end
		end else if (fn == qzoc_pkg::FN_RESET) begin
			clear_offset();
			res = offset;
			st = qzoc_pkg::ST_RESET;
		end else if (fn != qzoc_pkg::FN_APPLY) begin
			st = qzoc_pkg::ST_ZERO_REJ;
		end else if (!offset_set) begin
			res = q;
			st = qzoc_pkg::ST_PASS;
		end else if (dev_of(norm_of(q)) > valid_tol) begin
			res[0] = 16384; res[1] = 0; res[2] = 0; res[3] = 0;
			st = qzoc_pkg::ST_INVALID;
		end else begin
			p[0] = round_q(offset[0]*q[0] - offset[1]*q[1] - offset[2]*q[2] - offset[3]*q[3]);
			p[1] = round_q(offset[0]*q[1] + offset[1]*q[0] + offset[2]*q[3] - offset[3]*q[2]);
			p[2] = round_q(offset[0]*q[2] - offset[1]*q[3] + offset[2]*q[0] + offset[3]*q[1]);
			p[3] = round_q(offset[0]*q[3] + offset[1]*q[2] - offset[2]*q[1] + offset[3]*q[0]);
			last_dev = dev_of(unit_scale(p, res));
			st = qzoc_pkg::ST_CORR;
			if (last_dev > drift_thr) begin
				if (drift_run < 15) drift_run++;
				if (drift_run >= drift_lim) begin
					clear_offset();
					drift_run = 0;
					recal = 1;
					st = qzoc_pkg::ST_DRIFT;
				end
			end else begin
				drift_run = 0;
			end
			if (st == qzoc_pkg::ST_CORR) begin
				samples_seen++;
				if (check_int != 0 && samples_seen % check_int == 0 && last_dev > renorm_thr) begin
					t = offset;
					void'(unit_scale(t, offset));
					renorm_count++;
				end
			end
		end
		e.w = res[0][15:0]; e.x = res[1][15:0]; e.y = res[2][15:0]; e.z = res[3][15:0];
		e.st = st; e.recal = recal; e.active = offset_set;
		e.samples = samples_seen; e.renorms = renorm_count; e.dev = last_dev[14:0];
		pending_results.push_back(e);
	endfunction

	function void check_sample(quat_result_t a);
		quat_result_t e;
		if (pending_results.size() == 0) begin
			errors++;
			if (reported++ < 10) $display("%0t: result with nothing expected", $realtime);
			return;
		end
		e = pending_results.pop_front();
		status_seen[a.st]++;
		if (a.w !== e.w || a.x !== e.x || a.y !== e.y || a.z !== e.z || a.st !== e.st ||
		    a.recal !== e.recal || a.active !== e.active || a.samples !== e.samples ||
		    a.renorms !== e.renorms || a.dev !== e.dev) begin
			errors++;
			if (reported++ < 10) begin
				$display("%0t: mismatch exp q=(%0d %0d %0d %0d) st=%0d rc=%0d act=%0d n=%0d c=%0d d=%0d",
					$realtime, e.w, e.x, e.y, e.z, e.st, e.recal, e.active, e.samples,
					e.renorms, e.dev);
				$display("%0t:          got q=(%0d %0d %0d %0d) st=%0d rc=%0d act=%0d n=%0d c=%0d d=%0d",
					$realtime, a.w, a.x, a.y, a.z, a.st, a.recal, a.active, a.samples,
					a.renorms, a.dev);
			end
		end
	endfunction

	function bit busy();
		return pending_results.size() != 0;
	endfunction
endclass

module tb;
	import qzoc_pkg::*;

	localparam logic [1:0] FN_UNKNOWN = 2'd3;
	localparam int STALL_LIMIT = 20000;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0, out_ready = 0, cfg_valid = 0;
	logic in_ready, out_valid, cfg_ready;
	logic [1:0] func = FN_APPLY;
	logic signed [15:0] q_w = 0, q_x = 0, q_y = 0, q_z = 0;
	logic signed [15:0] out_w, out_x, out_y, out_z;
	logic [2:0] status;
	logic recalibrate, offset_active;
	logic [31:0] sample_count, correction_count;
	logic [14:0] norm_deviation;
	logic [2:0] cfg_index = CFG_VALID_TOL;
	logic [15:0] cfg_data = 0;

	corrected_quat_board sb = new();
	int idle_cycles = 0;
	int burst_left = 0;
	int items_sent = 0;
	bit hold_req = 0;

	always #4 clk = ~clk;

	quaternion_zero_offset_corrector_top u_top (.*);

	always @(posedge clk) begin
		quat_result_t r;
		if (in_valid && in_ready) sb.note_sample(func, q_w, q_x, q_y, q_z);
		if (out_valid && out_ready) begin
			r.w = out_w; r.x = out_x; r.y = out_y; r.z = out_z; r.st = status;
			r.recal = recalibrate; r.active = offset_active; r.samples = sample_count;
			r.renorms = correction_count; r.dev = norm_deviation;
			sb.check_sample(r);
		end
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
			$display("tb NOT OK");
			$finish;
		end
	end

	// Receiver: stall density changes at random intervals, plus one long hold-off.
	initial begin
		int stall_pct, left;
		stall_pct = 0;
		left = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 0;
				repeat (1500) @(posedge clk);
				hold_req = 0;
			end else begin
				if (left == 0) begin
					case ($urandom_range(3))
						0, 1: stall_pct = 0;
						2: stall_pct = 30;
						default: stall_pct = 75;
					endcase
					left = $urandom_range(400, 50);
				end
				left--;
				out_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// A gap follows each burst, so valid really drops between bursts.
	task automatic send_item(logic [1:0] fn, int w, int x, int y, int z);
		in_valid <= 1;
		func <= fn; q_w <= 16'(w); q_x <= 16'(x); q_y <= 16'(y); q_z <= 16'(z);
		do @(posedge clk); while (!in_ready);
		items_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid <= 0;
			repeat ($urandom_range(8, 1)) @(posedge clk);
			burst_left = $urandom_range(20);
		end
	endtask

	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (sb.busy()) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] data);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	// Random direction scaled near unit length, then disturbed by up to noise per component.
	task automatic send_unitish(logic [1:0] fn, int noise);
		quat_t c, u;
		for (int i = 0; i < 4; i++) c[i] = longint'($urandom_range(32768)) - 16384;
		void'(sb.unit_scale(c, u));
		for (int i = 0; i < 4; i++)
			u[i] = sb.sat16(u[i] + longint'($urandom_range(2 * noise)) - noise);
		send_item(fn, u[0][15:0], u[1][15:0], u[2][15:0], u[3][15:0]);
	endtask

	task automatic send_random(int n);
		int pick;
		logic [31:0] a, b;
		for (int k = 0; k < n; k++) begin
			pick = $urandom_range(99);
			if (pick < 62) begin
				send_unitish(FN_APPLY, $urandom_range(1) ? 20 : 1500);
			end else if (pick < 76) begin
				send_unitish(FN_ZERO, $urandom_range(1) ? 10 : 2000);
			end else if (pick < 80) begin
				send_item(FN_RESET, $urandom, $urandom, $urandom, $urandom);
			end else begin
				a = $urandom;
				b = $urandom;
				send_item(2'($urandom_range(3)), a[15:0], a[31:16], b[15:0], b[31:16]);
			end
		end
	endtask

	task automatic set_regs(int vt, int dt, int dl, int ci, int rt);
		write_reg(CFG_VALID_TOL, 16'(vt));
		write_reg(CFG_DRIFT_THR, 16'(dt));
		write_reg(CFG_DRIFT_LIM, 16'(dl));
		write_reg(CFG_CHECK_INT, 16'(ci));
		write_reg(CFG_RENORM_THR, 16'(rt));
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		// Directed part at reset settings.
		send_item(FN_APPLY, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
		send_item(FN_APPLY, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
		send_item(FN_APPLY, 0, 0, 0, 0);
		send_item(FN_UNKNOWN, 100, 200, 300, 400);
		send_item(FN_ZERO, 0, 0, 0, 0);
		send_item(FN_ZERO, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
		send_item(FN_ZERO, 16384, 0, 0, 0);
		send_item(FN_APPLY, 16384, 0, 0, 0);
		send_item(FN_APPLY, 0, 0, 0, 0);
		send_item(FN_APPLY, -16'sd32768, 0, 0, 0);
		send_item(FN_ZERO, 8192, 8192, 8192, 8192);
		send_item(FN_APPLY, 0, 16384, 0, 0);
		send_item(FN_APPLY, -8192, 8192, -8192, 8192);
		send_item(FN_UNKNOWN, 0, 0, 0, 0);
		send_item(FN_RESET, 1, 2, 3, 4);
		send_item(FN_APPLY, 5, -5, 7, -7);
		drain();

		// Everything valid, any nonzero norm deviation counts as drift, limit zero and no periodic check.
		set_regs(32767, 0, 0, 0, 0);
		send_item(FN_ZERO, 0, 0, 0, 0);
		send_item(FN_APPLY, 0, 0, 0, 0);
		send_item(FN_ZERO, 16'sh7fff, -16'sd32768, 16'sh7fff, -16'sd32768);
		send_item(FN_APPLY, 16'sh7fff, 16'sh7fff, -16'sd32768, -16'sd32768);
		send_random(120);
		drain();

		set_regs(0, 32767, 15, 65535, 32767);
		send_random(120);
		drain();

		set_regs(1638, 1638, 5, 3, 0);
		send_item(FN_ZERO, 16384, 0, 0, 0);
		hold_req = 1;
		send_random(260);
		drain();

		set_regs(2000, 60, 3, 1, 0);
		send_random(260);
		drain();

		set_regs(2500, 300, 1, 7, 10);
		send_random(260);
		drain();

		set_regs($urandom_range(32767), $urandom_range(3000), $urandom_range(15),
			$urandom_range(12), $urandom_range(200));
		send_random(200);
		drain();

		set_regs(1638, 1638, 5, 1000, 82);
		send_random(200);
		drain();
		repeat (50) @(posedge clk);

		$display("%0d items sent over eight register settings", items_sent);
		$display("results by status: corr %0d pass %0d inv %0d drift %0d set %0d rej %0d rst %0d",
			sb.status_seen[ST_CORR], sb.status_seen[ST_PASS], sb.status_seen[ST_INVALID],
			sb.status_seen[ST_DRIFT], sb.status_seen[ST_ZERO_SET], sb.status_seen[ST_ZERO_REJ],
			sb.status_seen[ST_RESET]);
		if (sb.errors == 0 && !sb.busy())
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end
endmodule
